FILE: src/sfas_pkg.sv
`default_nettype none
package sfas_pkg;

  localparam int ANGLE_STEPS_LOG2 = 16;
  localparam int QR_W = ANGLE_STEPS_LOG2 - 2;
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
  localparam logic [63:0] PI_HI = PI_Q60 >> (ANGLE_STEPS_LOG2 - 1);
  localparam logic [63:0] PI_LO = PI_Q60 & ((64'd1 << (ANGLE_STEPS_LOG2 - 1)) - 64'd1);

  localparam int HORNER_TERMS = 13;
  localparam int DIV_CHUNKS = 4;
  localparam int CHUNK_W = 16;
  localparam int REM_W = 10;
  localparam int V_W = REM_W + CHUNK_W;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W = 34;
  localparam int PROD_W = V_W + RECIP_W;
  localparam int CELL_LAT = 2 + 2 * DIV_CHUNKS;
  localparam int SINE_LAT = 4 + HORNER_TERMS * CELL_LAT + 2;

  localparam int VAL_W = 13;
  localparam logic [VAL_W-1:0] SINE_ONE = VAL_W'(4096);
  localparam int Q_W = VAL_W + 8;
  localparam int DEN_W = 32;
  localparam logic [15:0] MAT_ONE = 16'h0100;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_ZERO  = 3'd2,
    ST_SAT   = 3'd3,
    ST_KIND  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,
    KIND_ROT   = 2'd1,
    KIND_POS   = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  typedef struct packed {
    logic [Q_W-1:0]   num;
    logic [Q_W-1:0]   quo;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
  } div_t;

  typedef struct packed {
    status_t          status;
    logic             rot;
    logic [15:0]      cell_id;
    logic [15:0]      ox;
    logic [15:0]      oy;
    logic             s_zero;
    logic             s_full;
    logic             s_neg;
    logic             c_zero;
    logic             c_full;
    logic             c_neg;
    logic             sx_neg;
    logic             sy_neg;
    logic             sx_zero;
    logic             sy_zero;
    logic [DEN_W-1:0] sx_mag;
    logic [DEN_W-1:0] sy_mag;
  } side_t;

  typedef struct packed {
    logic [15:0] val;
    logic        sat;
  } entry_t;

  // bits 123:60 of the product given as four 32x32 partial products
  function automatic logic [63:0] q60_sum(input logic [63:0] p00, input logic [63:0] p01,
                                          input logic [63:0] p10, input logic [63:0] p11);
    logic [127:0] full;
    full = {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32) + {p11, 64'd0};
    return full[123:60];
  endfunction

endpackage
`default_nettype wire

FILE: src/sfas_horner_cell.sv
`default_nettype none
module sfas_horner_cell (
  input  logic                          clk,
  input  logic                          en,
  input  logic [sfas_pkg::REM_W-1:0]    d,
  input  logic [sfas_pkg::RECIP_W-1:0]  m,
  input  logic [63:0]                   x_in,
  input  logic [63:0]                   x2_in,
  input  logic [63:0]                   acc_in,
  output logic [63:0]                   x_out,
  output logic [63:0]                   x2_out,
  output logic [63:0]                   acc_out
);

  localparam int NC = sfas_pkg::DIV_CHUNKS;

  logic [63:0] xs  [sfas_pkg::CELL_LAT];
  logic [63:0] x2s [sfas_pkg::CELL_LAT];
  logic [63:0] pp  [4];
  logic [63:0] p;

  logic [sfas_pkg::V_W-1:0]     v1    [NC];
  logic [sfas_pkg::CHUNK_W-1:0] q1    [NC];
  logic [63:0]                  qacc1 [NC];
  logic [63:0]                  pc1   [NC];
  logic [sfas_pkg::REM_W-1:0]   rem2  [NC-1];
  logic [63:0]                  qacc2 [NC-1];
  logic [63:0]                  pc2   [NC-1];
  logic [63:0]                  acc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0]  <= x_in;
      x2s[0] <= x2_in;
      for (int i = 1; i < sfas_pkg::CELL_LAT; i++) begin
        xs[i]  <= xs[i-1];
        x2s[i] <= x2s[i-1];
      end
      pp[0] <= 64'(x2_in[31:0]) * 64'(acc_in[31:0]);
      pp[1] <= 64'(x2_in[31:0]) * 64'(acc_in[63:32]);
      pp[2] <= 64'(x2_in[63:32]) * 64'(acc_in[31:0]);
      pp[3] <= 64'(x2_in[63:32]) * 64'(acc_in[63:32]);
      p     <= sfas_pkg::q60_sum(pp[0], pp[1], pp[2], pp[3]);
    end
  end

  // long division of p by d, one 16-bit chunk per two stages
  for (genvar k = 0; k < NC; k++) begin : g_chunk
    logic [sfas_pkg::REM_W-1:0]  rem_in;
    logic [63:0]                 qacc_in;
    logic [63:0]                 p_in;
    logic [sfas_pkg::V_W-1:0]    v;
    logic [sfas_pkg::PROD_W-1:0] prod;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign qacc_in = '0;
      assign p_in    = p;
    end else begin : g_next
      assign rem_in  = rem2[k-1];
      assign qacc_in = qacc2[k-1];
      assign p_in    = pc2[k-1];
    end

    assign v    = {rem_in, p_in[63 - k * sfas_pkg::CHUNK_W -: sfas_pkg::CHUNK_W]};
    assign prod = sfas_pkg::PROD_W'(v) * sfas_pkg::PROD_W'(m);

    always_ff @(posedge clk) begin
      if (en) begin
        v1[k]    <= v;
        q1[k]    <= prod[sfas_pkg::RECIP_SHIFT +: sfas_pkg::CHUNK_W];
        qacc1[k] <= qacc_in;
        pc1[k]   <= p_in;
      end
    end

    if (k < NC - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem2[k]  <= sfas_pkg::REM_W'(v1[k] - sfas_pkg::V_W'(q1[k]) * sfas_pkg::V_W'(d));
          qacc2[k] <= {qacc1[k][63-sfas_pkg::CHUNK_W:0], q1[k]};
          pc2[k]   <= pc1[k];
        end
      end
    end else begin : g_acc
      always_ff @(posedge clk) begin
        if (en) begin
          acc_r <= sfas_pkg::ONE_Q60 - {qacc1[k][63-sfas_pkg::CHUNK_W:0], q1[k]};
        end
      end
    end
  end

  assign x_out   = xs[sfas_pkg::CELL_LAT-1];
  assign x2_out  = x2s[sfas_pkg::CELL_LAT-1];
  assign acc_out = acc_r;

endmodule
`default_nettype wire

FILE: src/sfas_sine.sv
`default_nettype none
module sfas_sine (
  input  logic                        clk,
  input  logic                        en,
  input  logic [sfas_pkg::QR_W-1:0]   r,
  output logic [sfas_pkg::VAL_W-1:0]  val
);

  localparam int T = sfas_pkg::HORNER_TERMS;

  logic [63:0] pa, pb, pc, x0, xa, xb, x2_0;
  logic [63:0] xp [4];
  logic [63:0] fp [4];
  logic [63:0] fsum;
  logic [63:0] xc   [T+1];
  logic [63:0] x2c  [T];
  logic [63:0] accc [T+1];

  always_ff @(posedge clk) begin
    if (en) begin
      pa    <= 64'(sfas_pkg::PI_HI[31:0]) * 64'(r);
      pb    <= 64'(sfas_pkg::PI_HI[63:32]) * 64'(r);
      pc    <= (sfas_pkg::PI_LO * 64'(r)) >> (sfas_pkg::ANGLE_STEPS_LOG2 - 1);
      x0    <= pa + (pb << 32) + pc;
      xp[0] <= 64'(x0[31:0]) * 64'(x0[31:0]);
      xp[1] <= 64'(x0[31:0]) * 64'(x0[63:32]);
      xp[2] <= 64'(x0[63:32]) * 64'(x0[31:0]);
      xp[3] <= 64'(x0[63:32]) * 64'(x0[63:32]);
      xa    <= x0;
      x2_0  <= sfas_pkg::q60_sum(xp[0], xp[1], xp[2], xp[3]);
      xb    <= xa;
    end
  end

  assign xc[0]   = xb;
  assign x2c[0]  = x2_0;
  assign accc[0] = sfas_pkg::ONE_Q60;

  // horner series, highest term first
  for (genvar i = 0; i < T; i++) begin : g_cell
    localparam int N = T - i;
    localparam logic [63:0] D64 = 64'(2 * N * (2 * N + 1));
    localparam logic [sfas_pkg::REM_W-1:0] D = sfas_pkg::REM_W'(D64);
    localparam logic [sfas_pkg::RECIP_W-1:0] M =
      sfas_pkg::RECIP_W'(((64'd1 << sfas_pkg::RECIP_SHIFT) + D64 - 64'd1) / D64);
    if (i < T - 1) begin : g_mid
      sfas_horner_cell u_cell (
        .clk(clk), .en(en), .d(D), .m(M),
        .x_in(xc[i]), .x2_in(x2c[i]), .acc_in(accc[i]),
        .x_out(xc[i+1]), .x2_out(x2c[i+1]), .acc_out(accc[i+1])
      );
    end else begin : g_last
      sfas_horner_cell u_cell (
        .clk(clk), .en(en), .d(D), .m(M),
        .x_in(xc[i]), .x2_in(x2c[i]), .acc_in(accc[i]),
        .x_out(xc[i+1]), .x2_out(), .acc_out(accc[i+1])
      );
    end
  end

  assign fsum = sfas_pkg::q60_sum(fp[0], fp[1], fp[2], fp[3]);

  always_ff @(posedge clk) begin
    if (en) begin
      fp[0] <= 64'(xc[T][31:0]) * 64'(accc[T][31:0]);
      fp[1] <= 64'(xc[T][31:0]) * 64'(accc[T][63:32]);
      fp[2] <= 64'(xc[T][63:32]) * 64'(accc[T][31:0]);
      fp[3] <= 64'(xc[T][63:32]) * 64'(accc[T][63:32]);
      val   <= fsum[48 +: sfas_pkg::VAL_W];
    end
  end

endmodule
`default_nettype wire

FILE: src/sfas_div_cell.sv
`default_nettype none
module sfas_div_cell (
  input  logic           clk,
  input  logic           en,
  input  sfas_pkg::div_t d_in,
  output sfas_pkg::div_t d_out
);

  logic [sfas_pkg::DEN_W:0] trial;
  logic [sfas_pkg::DEN_W:0] diff;
  logic                     ge;

  assign trial = {d_in.rem, d_in.num[sfas_pkg::Q_W-1]};
  assign diff  = trial - {1'b0, d_in.den};
  assign ge    = trial >= {1'b0, d_in.den};

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.num <= {d_in.num[sfas_pkg::Q_W-2:0], 1'b0};
      d_out.quo <= {d_in.quo[sfas_pkg::Q_W-2:0], ge};
      d_out.rem <= ge ? diff[sfas_pkg::DEN_W-1:0] : trial[sfas_pkg::DEN_W-1:0];
      d_out.den <= d_in.den;
    end
  end

endmodule
`default_nettype wire

FILE: src/sprite_frame_affine_setup_unit.sv
`default_nettype none
// Frame record to affine setup. Fully pipelined: one item per cycle while the
// output is not stalled. From input to output register the path runs through the
// sine and cosine series (13 chained Horner cells of 10 stages each, plus 6 stages
// around them) and the 21-stage restoring divider rows behind them. When a
// result waits at the output the whole pipeline holds only once its last stage
// is also full; until then new items keep entering.
module sprite_frame_affine_setup_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         frame_kind,
  input  logic [15:0]        frame_number,
  input  logic [15:0]        frames_in_animation,
  input  logic [15:0]        cell_number,
  input  logic signed [15:0] angle,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [15:0]        cell_out,
  output logic signed [15:0] mat_a,
  output logic signed [15:0] mat_b,
  output logic signed [15:0] mat_c,
  output logic signed [15:0] mat_d,
  output logic signed [15:0] off_x,
  output logic signed [15:0] off_y
);

  localparam int LOG2 = sfas_pkg::ANGLE_STEPS_LOG2;
  localparam int QW = sfas_pkg::QR_W;
  localparam int SL = sfas_pkg::SINE_LAT;
  localparam int QN = sfas_pkg::Q_W;
  localparam int SIDE_LEN = SL + QN + 1;
  localparam int LAST = SIDE_LEN - 1;
  localparam logic [QW:0] QUARTER = (QW+1)'(1) << QW;

  logic adv, move;
  logic pv [SIDE_LEN];
  sfas_pkg::side_t side [SIDE_LEN];
  sfas_pkg::side_t side_in;

  logic [LOG2-1:0] idx;
  logic [1:0]      qs, qcq;
  logic [QW-1:0]   r;
  logic [QW:0]     rs_arg, rc_arg;
  logic [sfas_pkg::VAL_W-1:0] val_s, val_c, s_mag, c_mag;

  sfas_pkg::div_t dv [4][QN+1];

  sfas_pkg::status_t  status_r, status_next;
  logic [15:0]        cell_r, cell_next;
  logic [15:0]        ma_r, mb_r, mc_r, md_r, ox_r, oy_r;
  logic [15:0]        ma_next, mb_next, mc_next, md_next, ox_next, oy_next;
  sfas_pkg::entry_t   ea, eb, ec, ed;

  assign adv      = !pv[LAST] || !out_valid || out_ready;
  assign move     = pv[LAST] && (!out_valid || out_ready);
  assign in_ready = adv;

  // angle decode
  assign idx    = angle[15 -: LOG2];
  assign qs     = idx[LOG2-1 -: 2];
  assign qcq    = qs + 2'd1;
  assign r      = idx[QW-1:0];
  assign rs_arg = qs[0] ? QUARTER - {1'b0, r} : {1'b0, r};
  assign rc_arg = qcq[0] ? QUARTER - {1'b0, r} : {1'b0, r};

  always_comb begin
    side_in = '0;
    if (frame_number >= frames_in_animation) begin
      side_in.status = sfas_pkg::ST_RANGE;
    end else if (frame_kind == sfas_pkg::KIND_BAD) begin
      side_in.status = sfas_pkg::ST_KIND;
    end else begin
      side_in.status = sfas_pkg::ST_OK;
    end
    side_in.rot     = frame_kind == sfas_pkg::KIND_ROT;
    side_in.cell_id = cell_number;
    if (frame_kind == sfas_pkg::KIND_ROT || frame_kind == sfas_pkg::KIND_POS) begin
      side_in.ox = pos_x;
      side_in.oy = pos_y;
    end
    side_in.s_zero  = rs_arg == '0;
    side_in.s_full  = rs_arg[QW];
    side_in.s_neg   = qs[1];
    side_in.c_zero  = rc_arg == '0;
    side_in.c_full  = rc_arg[QW];
    side_in.c_neg   = qcq[1];
    side_in.sx_neg  = scale_x[31];
    side_in.sy_neg  = scale_y[31];
    side_in.sx_zero = scale_x == '0;
    side_in.sy_zero = scale_y == '0;
    side_in.sx_mag  = scale_x[31] ? 32'(-scale_x) : 32'(scale_x);
    side_in.sy_mag  = scale_y[31] ? 32'(-scale_y) : 32'(scale_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SIDE_LEN; i++) begin
        pv[i] <= 1'b0;
      end
    end else if (adv) begin
      pv[0] <= in_valid;
      for (int i = 1; i < SIDE_LEN; i++) begin
        pv[i] <= pv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= side_in;
      for (int i = 1; i < SIDE_LEN; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  sfas_sine u_sin (.clk(clk), .en(adv), .r(rs_arg[QW-1:0]), .val(val_s));
  sfas_sine u_cos (.clk(clk), .en(adv), .r(rc_arg[QW-1:0]), .val(val_c));

  assign s_mag = side[SL-1].s_zero ? '0 : side[SL-1].s_full ? sfas_pkg::SINE_ONE : val_s;
  assign c_mag = side[SL-1].c_zero ? '0 : side[SL-1].c_full ? sfas_pkg::SINE_ONE : val_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0][0] <= '{num: {c_mag, 8'd0}, quo: '0, rem: '0, den: side[SL-1].sx_mag};
      dv[1][0] <= '{num: {s_mag, 8'd0}, quo: '0, rem: '0, den: side[SL-1].sx_mag};
      dv[2][0] <= '{num: {s_mag, 8'd0}, quo: '0, rem: '0, den: side[SL-1].sy_mag};
      dv[3][0] <= '{num: {c_mag, 8'd0}, quo: '0, rem: '0, den: side[SL-1].sy_mag};
    end
  end

  for (genvar rw = 0; rw < 4; rw++) begin : g_row
    for (genvar j = 0; j < QN; j++) begin : g_bit
      sfas_div_cell u_div (.clk(clk), .en(adv), .d_in(dv[rw][j]), .d_out(dv[rw][j+1]));
    end
  end

  function automatic sfas_pkg::entry_t clamp_q(input logic [QN-1:0] q, input logic neg,
                                               input logic zero);
    sfas_pkg::entry_t e;
    e = '0;
    if (zero) begin
      e.val = '0;
    end else if (!neg) begin
      if (q > QN'(32767)) begin
        e.val = 16'h7FFF;
        e.sat = 1'b1;
      end else begin
        e.val = q[15:0];
      end
    end else begin
      if (q > QN'(32768)) begin
        e.val = 16'h8000;
        e.sat = 1'b1;
      end else begin
        e.val = 16'(-q[15:0]);
      end
    end
    return e;
  endfunction

  assign ea = clamp_q(dv[0][QN].quo, side[LAST].c_neg ^ side[LAST].sx_neg, side[LAST].sx_zero);
  assign eb = clamp_q(dv[1][QN].quo, side[LAST].s_neg ^ side[LAST].sx_neg, side[LAST].sx_zero);
  assign ec = clamp_q(dv[2][QN].quo, !side[LAST].s_neg ^ side[LAST].sy_neg,
                      side[LAST].sy_zero);
  assign ed = clamp_q(dv[3][QN].quo, side[LAST].c_neg ^ side[LAST].sy_neg, side[LAST].sy_zero);

  always_comb begin
    status_next = side[LAST].status;
    cell_next   = '0;
    ma_next     = '0;
    mb_next     = '0;
    mc_next     = '0;
    md_next     = '0;
    ox_next     = '0;
    oy_next     = '0;
    if (side[LAST].status == sfas_pkg::ST_OK) begin
      cell_next = side[LAST].cell_id;
      ox_next   = side[LAST].ox;
      oy_next   = side[LAST].oy;
      if (side[LAST].rot) begin
        ma_next = ea.val;
        mb_next = eb.val;
        mc_next = ec.val;
        md_next = ed.val;
        if (side[LAST].sx_zero || side[LAST].sy_zero) begin
          status_next = sfas_pkg::ST_ZERO;
        end else if (ea.sat || eb.sat || ec.sat || ed.sat) begin
          status_next = sfas_pkg::ST_SAT;
        end
      end else begin
        ma_next = sfas_pkg::MAT_ONE;
        md_next = sfas_pkg::MAT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      status_r <= status_next;
      cell_r   <= cell_next;
      ma_r     <= ma_next;
      mb_r     <= mb_next;
      mc_r     <= mc_next;
      md_r     <= md_next;
      ox_r     <= ox_next;
      oy_r     <= oy_next;
    end
  end

  assign status   = status_r;
  assign cell_out = cell_r;
  assign mat_a    = ma_r;
  assign mat_b    = mb_r;
  assign mat_c    = mc_r;
  assign mat_d    = md_r;
  assign off_x    = ox_r;
  assign off_y    = oy_r;

endmodule
`default_nettype wire
